>>> rtl/core/asalu_pkg.sv
// shared types, constants and tables of the attribute script alu
`timescale 1ns / 1ps

package asalu_pkg;

   localparam int ENTRY_COUNT   = 256;
   localparam int FRACTION_BITS = 16;
   localparam int IDX_W         = $clog2(ENTRY_COUNT);

   localparam int DIV_W         = 32 + FRACTION_BITS;
   localparam int SQ_TOP        = (DIV_W - 1) & ~1;
   localparam int SQ_STEPS      = SQ_TOP / 2 + 1;
   localparam int CORDIC_STEPS  = 24;
   localparam int CNT_W         = $clog2(DIV_W + 1);
   localparam int SAT_W         = 67;

   localparam logic [31:0] TURN_SCALE      = 32'd2734261102;
   localparam logic [31:0] PI_Q29          = 32'd1686629713;
   localparam logic [31:0] CORDIC_GAIN_Q30 = 32'd652032874;

   // opcode map
   localparam logic [5:0] OP_ARITH_LAST = 6'd15;
   localparam logic [5:0] OP_COPY_SRC   = 6'd16;
   localparam logic [5:0] OP_COPY_IMM   = 6'd17;
   localparam logic [5:0] OP_CMP_FIRST  = 6'd18;
   localparam logic [5:0] OP_CMP_LAST   = 6'd37;
   localparam logic [5:0] OP_SQRT_SRC   = 6'd38;
   localparam logic [5:0] OP_SQRT_IMM   = 6'd39;
   localparam logic [5:0] OP_SIN_SRC    = 6'd42;
   localparam logic [5:0] OP_TRIG_LAST  = 6'd43;

   localparam logic [1:0] ARITH_ADD = 2'd0;
   localparam logic [1:0] ARITH_SUB = 2'd1;
   localparam logic [1:0] ARITH_MUL = 2'd2;
   localparam logic [1:0] ARITH_DIV = 2'd3;

   localparam logic [2:0] CMP_LT = 3'd0;
   localparam logic [2:0] CMP_LE = 3'd1;
   localparam logic [2:0] CMP_EQ = 3'd2;
   localparam logic [2:0] CMP_GT = 3'd3;
   localparam logic [2:0] CMP_GE = 3'd4;

   typedef enum logic [1:0] {
      STAT_OK       = 2'd0,
      STAT_BAD_OP   = 2'd1,
      STAT_DIV_ZERO = 2'd2,
      STAT_NEG_ROOT = 2'd3
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_OPER, ST_MUL, ST_DIV, ST_DIVEND, ST_SQRT,
      ST_TRIG1, ST_TRIG2, ST_CORDIC, ST_TRIGEND, ST_DONE
   } state_type;

   typedef struct packed {
      logic [5:0]         opcode;
      logic [7:0]         target_index;
      logic [7:0]         source_index;
      logic signed [31:0] immediate;
   } req_type;

   typedef struct packed {
      logic signed [31:0] written_value;
      logic [7:0]         written_index;
      logic signed [31:0] accumulator_value;
      status_type         status;
   } rsp_type;

   function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] v);
      logic signed [SAT_W-1:0] hi;
      logic signed [SAT_W-1:0] lo;
      hi = $signed({{(SAT_W-32){1'b0}}, 32'h7FFF_FFFF});
      lo = $signed({{(SAT_W-32){1'b1}}, 32'h8000_0000});
      if (v > hi) return 32'sh7FFF_FFFF;
      if (v < lo) return 32'sh8000_0000;
      return v[31:0];
   endfunction

   // truncated q30 arctangent table
   function automatic logic [31:0] atan_q30(input logic [4:0] i);
      case (i)
         5'd0:  return 32'h3243F6A8;
         5'd1:  return 32'h1DAC6705;
         5'd2:  return 32'h0FADBAFC;
         5'd3:  return 32'h07F56EA6;
         5'd4:  return 32'h03FEAB76;
         5'd5:  return 32'h01FFD55B;
         5'd6:  return 32'h00FFFAAA;
         5'd7:  return 32'h007FFF55;
         5'd8:  return 32'h003FFFEA;
         5'd9:  return 32'h001FFFFD;
         5'd10: return 32'h000FFFFF;
         5'd11: return 32'h0007FFFF;
         5'd12: return 32'h0003FFFF;
         5'd13: return 32'h0001FFFF;
         5'd14: return 32'h0000FFFF;
         5'd15: return 32'h00007FFF;
         5'd16: return 32'h00003FFF;
         5'd17: return 32'h00001FFF;
         5'd18: return 32'h00000FFF;
         5'd19: return 32'h000007FF;
         5'd20: return 32'h000003FF;
         5'd21: return 32'h000001FF;
         5'd22: return 32'h000000FF;
         5'd23: return 32'h0000007F;
         default: return 32'h0;
      endcase
   endfunction

endpackage

>>> rtl/core/attribute_script_alu.sv
// top level of the attribute script alu: store, sequencer and shared arithmetic units
`timescale 1ns / 1ps

// Executes one script operation per item on a store of ENTRY_COUNT signed
// fixed-point words held in a synchronous memory; entry 0 is the accumulator.
// Items are handled one at a time. Add, subtract, compare, copy and bad
// opcodes finish in ST_OPER and multiply in ST_MUL. Square root runs the
// two-bit-per-cycle root loop, divide the one-bit-per-cycle restoring
// divider and then ST_DIVEND, and sine and cosine ST_TRIG1, ST_TRIG2, the
// 24 step CORDIC loop and ST_TRIGEND. The store reads zero after reset
// through one valid bit per entry. A finished item waits in an output
// register, so the next item can be accepted meanwhile.
module attribute_script_alu (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  asalu_pkg::req_type req_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output asalu_pkg::rsp_type rsp_item
);
   import asalu_pkg::*;

   localparam int PH_LO = FRACTION_BITS + 2;

   // attribute store and per-entry valid bits
   logic [31:0]            store_mem [ENTRY_COUNT];
   logic [ENTRY_COUNT-1:0] vld_ff;
   logic [31:0]            lhs_mem_ff, rhs_mem_ff;
   logic                   lvld_ff, rvld_ff;

   state_type state_ff, state_in;
   req_type   item_ff, item_in;

   logic signed [31:0] res_ff, res_in;
   status_type         st_ff, st_in;
   logic [7:0]         dest_ff, dest_in;
   logic               wen_ff, wen_in;

   // shared multiplier product
   logic signed [65:0] prod_ff, prod_in;
   logic signed [32:0] mul_a, mul_b;

   // divider and root datapath
   logic [31:0]      rem_ff, rem_in;
   logic [DIV_W-1:0] quo_ff, quo_in;
   logic [31:0]      dvs_ff, dvs_in;
   logic             neg_ff, neg_in;
   logic [DIV_W-1:0] sres_ff, sres_in;
   logic [DIV_W-1:0] sbit_ff, sbit_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   // cordic datapath
   logic signed [33:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [31:0] cz_ff, cz_in;
   logic [1:0]         quad_ff, quad_in;
   logic               sin_ff, sin_in;

   logic signed [31:0] acc_ff, acc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic out_free;
   logic wr_en;

   // operand views
   logic signed [31:0] lhs, src, imm, rhs, opnd;
   logic [5:0]         op;
   logic [4:0]         cmp_k;
   logic [1:0]         cmp_grp;
   logic [2:0]         cmp_kind;
   logic               hit;
   logic [32:0]        trial;
   logic               ge;
   logic [DIV_W:0]     sq_t;
   logic [31:0]        phase, psum, dres;
   logic [1:0]         q;
   logic signed [33:0] shx, shy;
   logic signed [31:0] atan_v;
   logic signed [34:0] cv, sv, tv;
   logic signed [SAT_W-1:0] wide;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign wr_en     = (state_ff == ST_DONE) && out_free && wen_ff
                      && ({1'b0, dest_ff} < 9'(ENTRY_COUNT));
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // memory: two read ports for the operands, one write port for the result
   always_ff @(posedge clock) begin
      lhs_mem_ff <= store_mem[req_item.target_index[IDX_W-1:0]];
      rhs_mem_ff <= store_mem[req_item.source_index[IDX_W-1:0]];
      if (wr_en) begin
         store_mem[dest_ff[IDX_W-1:0]] <= res_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (wr_en) begin
         vld_ff[dest_ff[IDX_W-1:0]] <= 1'b1;
      end
   end

   // entries beyond the store and never written entries read as zero
   always_ff @(posedge clock) begin
      lvld_ff <= ({1'b0, req_item.target_index} < 9'(ENTRY_COUNT))
                 && vld_ff[req_item.target_index[IDX_W-1:0]];
      rvld_ff <= ({1'b0, req_item.source_index} < 9'(ENTRY_COUNT))
                 && vld_ff[req_item.source_index[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      res_ff  <= res_in;
      st_ff   <= st_in;
      dest_ff <= dest_in;
      wen_ff  <= wen_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      neg_ff  <= neg_in;
      sres_ff <= sres_in;
      sbit_ff <= sbit_in;
      cnt_ff  <= cnt_in;
      cx_ff   <= cx_in;
      cy_ff   <= cy_in;
      cz_ff   <= cz_in;
      quad_ff <= quad_in;
      sin_ff  <= sin_in;
      rsp_ff  <= rsp_in;
   end

   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      res_in       = res_ff;
      st_in        = st_ff;
      dest_in      = dest_ff;
      wen_in       = wen_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      dvs_in       = dvs_ff;
      neg_in       = neg_ff;
      sres_in      = sres_ff;
      sbit_in      = sbit_ff;
      cnt_in       = cnt_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      cz_in        = cz_ff;
      quad_in      = quad_ff;
      sin_in       = sin_ff;
      acc_in       = acc_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      op       = item_ff.opcode;
      lhs      = lvld_ff ? $signed(lhs_mem_ff) : 32'sd0;
      src      = rvld_ff ? $signed(rhs_mem_ff) : 32'sd0;
      imm      = item_ff.immediate;
      rhs      = op[2] ? imm : src;
      opnd     = op[0] ? imm : src;
      cmp_k    = 5'(op - OP_CMP_FIRST);
      cmp_grp  = (cmp_k >= 5'd15) ? 2'd3 : (cmp_k >= 5'd10) ? 2'd2 :
                 (cmp_k >= 5'd5) ? 2'd1 : 2'd0;
      cmp_kind = 3'(cmp_k - 5'(cmp_grp) * 5'd5);
      hit      = 1'b0;
      mul_a    = 33'(lhs);
      mul_b    = 33'(rhs);
      trial    = {rem_ff, quo_ff[DIV_W-1]};
      ge       = trial >= {1'b0, dvs_ff};
      sq_t     = {1'b0, sres_ff} + {1'b0, sbit_ff};
      phase    = prod_ff[PH_LO+31:PH_LO];
      psum     = phase + 32'h2000_0000;
      q        = psum[31:30];
      dres     = phase - {q, 30'b0};
      shx      = cx_ff >>> cnt_ff[4:0];
      shy      = cy_ff >>> cnt_ff[4:0];
      atan_v   = $signed(atan_q30(cnt_ff[4:0]));
      cv       = 35'(cx_ff);
      sv       = 35'(cy_ff);
      tv       = '0;
      wide     = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_item;
               state_in = ST_OPER;
            end
         end

         ST_OPER: begin
            st_in    = STAT_OK;
            wen_in   = 1'b1;
            dest_in  = item_ff.target_index;
            state_in = ST_DONE;
            if (op <= OP_ARITH_LAST) begin
               if (op[3]) dest_in = '0;
               case (op[1:0])
                  ARITH_ADD: res_in = sat32(SAT_W'(lhs) + SAT_W'(rhs));
                  ARITH_SUB: res_in = sat32(SAT_W'(lhs) - SAT_W'(rhs));
                  ARITH_MUL: begin
                     prod_in  = mul_a * mul_b;
                     state_in = ST_MUL;
                  end
                  default: begin
                     if (rhs == 32'sd0) begin
                        // divide by zero saturates toward the dividend's sign
                        st_in  = STAT_DIV_ZERO;
                        res_in = (lhs > 0) ? 32'sh7FFF_FFFF :
                                 (lhs < 0) ? 32'sh8000_0000 : 32'sd0;
                     end else begin
                        neg_in   = lhs[31] ^ rhs[31];
                        dvs_in   = rhs[31] ? 32'(-rhs) : rhs;
                        quo_in   = DIV_W'(lhs[31] ? 32'(-lhs) : lhs) << FRACTION_BITS;
                        rem_in   = '0;
                        cnt_in   = '0;
                        state_in = ST_DIV;
                     end
                  end
               endcase
            end else if (op == OP_COPY_SRC) begin
               res_in = src;
            end else if (op == OP_COPY_IMM) begin
               res_in = imm;
            end else if (op <= OP_CMP_LAST) begin
               rhs = cmp_grp[0] ? imm : src;
               if (cmp_grp[1]) dest_in = '0;
               case (cmp_kind)
                  CMP_LT:  hit = lhs < rhs;
                  CMP_LE:  hit = lhs <= rhs;
                  CMP_EQ:  hit = lhs == rhs;
                  CMP_GT:  hit = lhs > rhs;
                  CMP_GE:  hit = lhs >= rhs;
                  default: hit = 1'b0;
               endcase
               res_in = hit ? (32'sd1 <<< FRACTION_BITS) : 32'sd0;
            end else if (op == OP_SQRT_SRC || op == OP_SQRT_IMM) begin
               if (opnd < 0) begin
                  st_in  = STAT_NEG_ROOT;
                  res_in = '0;
               end else begin
                  quo_in   = DIV_W'(opnd) << FRACTION_BITS;
                  sres_in  = '0;
                  sbit_in  = DIV_W'(1) << SQ_TOP;
                  cnt_in   = '0;
                  state_in = ST_SQRT;
               end
            end else if (op <= OP_TRIG_LAST) begin
               // angle to turn phase
               mul_a    = 33'(opnd);
               mul_b    = $signed({1'b0, TURN_SCALE});
               prod_in  = mul_a * mul_b;
               sin_in   = op >= OP_SIN_SRC;
               state_in = ST_TRIG1;
            end else begin
               st_in   = STAT_BAD_OP;
               wen_in  = 1'b0;
               res_in  = '0;
               dest_in = '0;
            end
         end

         ST_MUL: begin
            wide     = (SAT_W'(prod_ff) + (SAT_W'(1) <<< (FRACTION_BITS - 1)))
                       >>> FRACTION_BITS;
            res_in   = sat32(wide);
            state_in = ST_DONE;
         end

         ST_DIV: begin
            rem_in = ge ? 32'(trial - {1'b0, dvs_ff}) : trial[31:0];
            quo_in = {quo_ff[DIV_W-2:0], ge};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(DIV_W - 1)) state_in = ST_DIVEND;
         end

         ST_DIVEND: begin
            wide     = $signed({{(SAT_W-DIV_W){1'b0}}, quo_ff});
            if (neg_ff) wide = -wide;
            res_in   = sat32(wide);
            state_in = ST_DONE;
         end

         ST_SQRT: begin
            if ({1'b0, quo_ff} >= sq_t) begin
               quo_in  = quo_ff - sq_t[DIV_W-1:0];
               sres_in = (sres_ff >> 1) + sbit_ff;
            end else begin
               sres_in = sres_ff >> 1;
            end
            sbit_in = sbit_ff >> 2;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(SQ_STEPS - 1)) begin
               res_in   = $signed(sres_in[31:0]);
               state_in = ST_DONE;
            end
         end

         ST_TRIG1: begin
            // nearest quadrant, residual scaled to radians
            quad_in  = q;
            mul_a    = 33'($signed(dres));
            mul_b    = $signed({1'b0, PI_Q29});
            prod_in  = mul_a * mul_b;
            state_in = ST_TRIG2;
         end

         ST_TRIG2: begin
            cz_in    = prod_ff[61:30];
            cx_in    = $signed({2'b00, CORDIC_GAIN_Q30});
            cy_in    = '0;
            cnt_in   = '0;
            state_in = ST_CORDIC;
         end

         ST_CORDIC: begin
            if (!cz_ff[31]) begin
               cx_in = cx_ff - shy;
               cy_in = cy_ff + shx;
               cz_in = cz_ff - atan_v;
            end else begin
               cx_in = cx_ff + shy;
               cy_in = cy_ff - shx;
               cz_in = cz_ff + atan_v;
            end
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == CNT_W'(CORDIC_STEPS - 1)) state_in = ST_TRIGEND;
         end

         ST_TRIGEND: begin
            case (quad_ff)
               2'd0: begin cv = 35'(cx_ff);  sv = 35'(cy_ff);  end
               2'd1: begin cv = -35'(cy_ff); sv = 35'(cx_ff);  end
               2'd2: begin cv = -35'(cx_ff); sv = -35'(cy_ff); end
               default: begin cv = 35'(cy_ff); sv = -35'(cx_ff); end
            endcase
            tv       = sin_ff ? sv : cv;
            wide     = (SAT_W'(tv) + (SAT_W'(1) <<< (29 - FRACTION_BITS)))
                       >>> (30 - FRACTION_BITS);
            res_in   = sat32(wide);
            state_in = ST_DONE;
         end

         ST_DONE: begin
            if (out_free) begin
               if (wr_en && dest_ff == 8'd0) acc_in = res_ff;
               rsp_in.written_value     = res_ff;
               rsp_in.written_index     = dest_ff;
               rsp_in.accumulator_value = acc_in;
               rsp_in.status            = st_ff;
               rsp_valid_in             = 1'b1;
               state_in                 = ST_IDLE;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

endmodule

>>> rtl/core/asalu_checker.sv
// port checker of the attribute script alu and its bind
`timescale 1ns / 1ps

module asalu_checker (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_stall,
   input asalu_pkg::req_type req_item,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input asalu_pkg::rsp_type rsp_item
);
   import asalu_pkg::*;

   // a stalled result item holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_item))
      else $error("result item changed while stalled");

   // a bad opcode writes nothing and reports zero
   a_bad_op: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status == STAT_BAD_OP
         |-> rsp_item.written_value == 32'sd0 && rsp_item.written_index == 8'd0)
      else $error("bad opcode item carries a value");

   // a write to entry 0 shows up as the accumulator
   a_acc_track: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.status != STAT_BAD_OP && rsp_item.written_index == 8'd0
         |-> rsp_item.accumulator_value == rsp_item.written_value)
      else $error("accumulator does not follow write to entry 0");

   // no item accepted while the previous one is still at work
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken while busy");

endmodule

bind attribute_script_alu asalu_checker u_asalu_checker (.*);
